FILE: src/ibbd_pkg.sv
// ----------------------------------------------------------------------------
// ibbd_pkg: shared types and constants
// Payload structs, register indexes and sizes for the bitplane blend decoder.
// ----------------------------------------------------------------------------
package ibbd_pkg;

	localparam int PIXELS_PER_WORD = 16;
	localparam int PIX_IDX_W       = $clog2(PIXELS_PER_WORD);
	localparam int PLANE_W         = 16;
	localparam int PLANES_MAX      = 4;
	localparam int WORDS_W         = PLANE_W * PLANES_MAX;
	localparam int COLOR_W         = 12;
	localparam int PAL_ENTRIES     = 16;
	localparam int PAL_PER_ROW     = 4;
	localparam int PAL_ROWS        = PAL_ENTRIES / PAL_PER_ROW;
	localparam int PAL_ROW_W       = COLOR_W * PAL_PER_ROW;
	localparam int PAL_ADDR_W      = $clog2(PAL_ROWS);
	localparam int PAL_SEL_W       = $clog2(PAL_PER_ROW);
	localparam int PLANE_CNT_W     = 3;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = PAL_ROW_W;

	localparam logic [PLANE_CNT_W-1:0] PLANE_COUNT_RST = 3'd4;
	localparam logic [PLANE_CNT_W-1:0] PLANE_COUNT_MAX = 3'd4;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAL_0       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PAL_1       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PAL_2       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PAL_3       = 3'd4;

	typedef struct packed {
		logic [WORDS_W-1:0] first_screen_words;
		logic [WORDS_W-1:0] second_screen_words;
	} in_item_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last_pixel;
	} out_item_t;

	typedef struct packed {
		logic                  en;
		logic [PAL_ADDR_W-1:0] addr;
		logic [PAL_ROW_W-1:0]  data;
	} pal_wr_t;

	typedef struct packed {
		logic                  en;
		logic [PAL_ADDR_W-1:0] addr_a;
		logic [PAL_ADDR_W-1:0] addr_b;
	} pal_rd_t;

endpackage

FILE: src/ibbd_pal.sv
// ----------------------------------------------------------------------------
// ibbd_pal: palette memory
// Four rows of four color words, one write port, two registered read ports.
// Rows read as zero until first written.
// ----------------------------------------------------------------------------
module ibbd_pal (
	input  logic                               clk,
	input  logic                               arst_n,
	input  ibbd_pkg::pal_wr_t                  wr,
	input  ibbd_pkg::pal_rd_t                  rd,
	output logic [ibbd_pkg::PAL_ROW_W-1:0]     rdata_a,
	output logic [ibbd_pkg::PAL_ROW_W-1:0]     rdata_b
);

	logic [ibbd_pkg::PAL_ROW_W-1:0] mem [ibbd_pkg::PAL_ROWS];
	logic [ibbd_pkg::PAL_ROWS-1:0]  row_vld_q;
	logic [ibbd_pkg::PAL_ROW_W-1:0] raw_a_s2;
	logic [ibbd_pkg::PAL_ROW_W-1:0] raw_b_s2;
	logic                           vld_a_s2;
	logic                           vld_b_s2;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd.en) begin
			raw_a_s2 <= mem[rd.addr_a];
			raw_b_s2 <= mem[rd.addr_b];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			vld_a_s2  <= 1'b0;
			vld_b_s2  <= 1'b0;
		end else begin
			if (wr.en) begin
				row_vld_q[wr.addr] <= 1'b1;
			end
			if (rd.en) begin
				vld_a_s2 <= row_vld_q[rd.addr_a];
				vld_b_s2 <= row_vld_q[rd.addr_b];
			end
		end
	end

	assign rdata_a = vld_a_s2 ? raw_a_s2 : '0;
	assign rdata_b = vld_b_s2 ? raw_b_s2 : '0;

endmodule

FILE: src/ibbd_blend.sv
// ----------------------------------------------------------------------------
// ibbd_blend: color expand and average
// Turns two STE color words into 8-bit channels and averages them.
// ----------------------------------------------------------------------------
module ibbd_blend (
	input  logic [ibbd_pkg::COLOR_W-1:0] color_a,
	input  logic [ibbd_pkg::COLOR_W-1:0] color_b,
	input  logic                         last_pixel,
	output ibbd_pkg::out_item_t          pixel
);

	// ste nibble: low three bits are the top of the level, bit 3 the lsb;
	// times 17 is the 4-bit value repeated
	function automatic logic [7:0] expand(input logic [3:0] nib);
		logic [3:0] v;
		v = {nib[2:0], nib[3]};
		return {v, v};
	endfunction

	function automatic logic [7:0] avg(input logic [3:0] na, input logic [3:0] nb);
		logic [8:0] sum;
		sum = {1'b0, expand(na)} + {1'b0, expand(nb)};
		return sum[8:1];
	endfunction

	always_comb begin
		pixel.red        = avg(color_a[11:8], color_b[11:8]);
		pixel.green      = avg(color_a[7:4], color_b[7:4]);
		pixel.blue       = avg(color_a[3:0], color_b[3:0]);
		pixel.last_pixel = last_pixel;
	end

endmodule

FILE: src/interlaced_bitplane_blend_decoder.sv
// ----------------------------------------------------------------------------
// interlaced_bitplane_blend_decoder: bitplane to rgb with two-screen blend
// Serializes one word group of each screen into sixteen averaged pixels.
// ----------------------------------------------------------------------------
// usage:
//   in channel (in_valid/in_stall/in_data) takes one word group per screen;
//   each transfer yields sixteen out transfers, leftmost pixel first, with
//   last_pixel set on the sixteenth.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes plane count
//   and palette rows; cfg_ready is always high; write only while idle.
//   the pixel counter of the input register steps one pixel per cycle
//   while out is not stalled, so a new group is taken in the cycle its
//   predecessor's last pixel moves on, and groups stream without gaps.
//   a pixel passes the input register, the palette read register and
//   then the output register before it shows on out.
//   a stalled out channel freezes the whole pixel pipe; in_stall rises
//   while a group is still being serialized.
//   reset: no group held, plane count 4, all palette entries read as zero.
// ----------------------------------------------------------------------------
module interlaced_bitplane_blend_decoder (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  ibbd_pkg::in_item_t                   in_data,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output ibbd_pkg::out_item_t                  out_data,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [ibbd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ibbd_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam logic [ibbd_pkg::PIX_IDX_W-1:0] PIX_LAST =
		ibbd_pkg::PIX_IDX_W'(ibbd_pkg::PIXELS_PER_WORD - 1);

	logic [ibbd_pkg::PLANE_CNT_W-1:0] plane_count_q;
	logic [ibbd_pkg::PLANE_CNT_W-1:0] planes_eff;
	logic [ibbd_pkg::CFG_IDX_W-1:0]   pal_off;
	ibbd_pkg::pal_wr_t                pal_wr;
	ibbd_pkg::pal_rd_t                pal_rd;

	ibbd_pkg::in_item_t               in_s1;
	logic                             valid_s1;
	logic [ibbd_pkg::PIX_IDX_W-1:0]   cnt_s1;

	logic [ibbd_pkg::PLANES_MAX-1:0]  idx_a;
	logic [ibbd_pkg::PLANES_MAX-1:0]  idx_b;

	logic                             valid_s2;
	logic                             last_s2;
	logic [ibbd_pkg::PAL_SEL_W-1:0]   sel_a_s2;
	logic [ibbd_pkg::PAL_SEL_W-1:0]   sel_b_s2;
	logic [ibbd_pkg::PAL_ROW_W-1:0]   row_a;
	logic [ibbd_pkg::PAL_ROW_W-1:0]   row_b;
	ibbd_pkg::out_item_t              pixel;

	ibbd_pkg::out_item_t              out_data_q;
	logic                             out_valid_q;

	logic                             adv;
	logic                             in_xfer;
	logic                             group_done;

	// configuration
	assign cfg_ready = 1'b1;
	assign pal_off   = cfg_index - ibbd_pkg::REG_PAL_0;

	always_comb begin
		pal_wr.en   = cfg_valid && (cfg_index == ibbd_pkg::REG_PAL_0 ||
			cfg_index == ibbd_pkg::REG_PAL_1 || cfg_index == ibbd_pkg::REG_PAL_2 ||
			cfg_index == ibbd_pkg::REG_PAL_3);
		pal_wr.addr = pal_off[ibbd_pkg::PAL_ADDR_W-1:0];
		pal_wr.data = cfg_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_count_q <= ibbd_pkg::PLANE_COUNT_RST;
		end else if (cfg_valid && cfg_index == ibbd_pkg::REG_PLANE_COUNT) begin
			plane_count_q <= cfg_data[ibbd_pkg::PLANE_CNT_W-1:0];
		end
	end

	assign planes_eff = (plane_count_q > ibbd_pkg::PLANE_COUNT_MAX) ?
		ibbd_pkg::PLANE_COUNT_MAX : plane_count_q;

	// flow control: the whole pixel pipe moves when the output register frees
	assign adv        = !out_valid_q || !out_stall;
	assign group_done = valid_s1 && adv && (cnt_s1 == '0);
	assign in_stall   = valid_s1 && !group_done;
	assign in_xfer    = in_valid && !in_stall;

	// stage 1: held group and pixel counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			cnt_s1   <= '0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
			cnt_s1   <= PIX_LAST;
		end else if (valid_s1 && adv) begin
			cnt_s1 <= cnt_s1 - 1'b1;
			if (cnt_s1 == '0) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			in_s1 <= in_data;
		end
	end

	// gather color indexes, one bit per plane
	always_comb begin
		logic [ibbd_pkg::PLANE_W-1:0] word_a;
		logic [ibbd_pkg::PLANE_W-1:0] word_b;
		for (int k = 0; k < ibbd_pkg::PLANES_MAX; k++) begin
			word_a   = in_s1.first_screen_words[k*ibbd_pkg::PLANE_W +: ibbd_pkg::PLANE_W];
			word_b   = in_s1.second_screen_words[k*ibbd_pkg::PLANE_W +: ibbd_pkg::PLANE_W];
			idx_a[k] = (ibbd_pkg::PLANE_CNT_W'(k) < planes_eff) && word_a[cnt_s1];
			idx_b[k] = (ibbd_pkg::PLANE_CNT_W'(k) < planes_eff) && word_b[cnt_s1];
		end
	end

	always_comb begin
		pal_rd.en     = adv;
		pal_rd.addr_a = idx_a[ibbd_pkg::PLANES_MAX-1:ibbd_pkg::PAL_SEL_W];
		pal_rd.addr_b = idx_b[ibbd_pkg::PLANES_MAX-1:ibbd_pkg::PAL_SEL_W];
	end

	ibbd_pal u_pal (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (pal_wr),
		.rd      (pal_rd),
		.rdata_a (row_a),
		.rdata_b (row_b)
	);

	// stage 2: palette rows read, entry select carried alongside
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sel_a_s2 <= idx_a[ibbd_pkg::PAL_SEL_W-1:0];
			sel_b_s2 <= idx_b[ibbd_pkg::PAL_SEL_W-1:0];
			last_s2  <= (cnt_s1 == '0);
		end
	end

	ibbd_blend u_blend (
		.color_a    (row_a[sel_a_s2*ibbd_pkg::COLOR_W +: ibbd_pkg::COLOR_W]),
		.color_b    (row_b[sel_b_s2*ibbd_pkg::COLOR_W +: ibbd_pkg::COLOR_W]),
		.last_pixel (last_s2),
		.pixel      (pixel)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q <= pixel;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

`ifndef SYNTHESIS
	a_take_only_at_group_end: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && valid_s1) |-> (cnt_s1 == '0 && adv))
		else $error("new group taken before the held group was serialized");

	a_counter_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv && cnt_s1 != '0 && !in_xfer) |=>
		(valid_s1 && cnt_s1 == $past(cnt_s1) - 1'b1))
		else $error("pixel counter did not step by one");

	a_pipe_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> (valid_s2 == $past(valid_s2) && cnt_s1 == $past(cnt_s1)))
		else $error("pixel pipe moved while the output was stalled");

	a_last_with_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && valid_s2 && last_s2) |=> (out_valid_q && out_data_q.last_pixel))
		else $error("last pixel flag lost on its way to the output");
`endif

endmodule
